// ----- rtl/core/masc_pkg.sv -----
package masc_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int AVERAGE_W     = 16;
  localparam int STEP_TOTAL_W  = 24;
  localparam int FLOOR_TOTAL_W = 16;
  localparam int THRESHOLD_W   = 16;
  localparam int SPF_W         = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 4;

  localparam int WINDOW_LEN_DEFAULT  = 5;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_FLOOR = CFG_INDEX_W'(1);

  localparam logic [THRESHOLD_W-1:0]   THRESHOLD_RESET = THRESHOLD_W'(384);
  localparam logic [SPF_W-1:0]         SPF_RESET       = SPF_W'(20);
  localparam logic [STEP_TOTAL_W-1:0]  STEP_MAX        = '1;
  localparam logic [FLOOR_TOTAL_W-1:0] FLOOR_MAX       = '1;

endpackage

// ----- rtl/core/masc_sample_if.sv -----
interface masc_sample_if;
  logic                          valid;
  logic                          ready;
  logic [masc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- rtl/core/masc_result_if.sv -----
interface masc_result_if;
  logic                               valid;
  logic                               ready;
  logic [masc_pkg::AVERAGE_W-1:0]     average;
  logic                               step_seen;
  logic [masc_pkg::STEP_TOTAL_W-1:0]  step_total;
  logic [masc_pkg::FLOOR_TOTAL_W-1:0] floor_total;
  logic                               floor_reached;

  modport source (
    output valid, output average, output step_seen, output step_total,
    output floor_total, output floor_reached, input ready
  );
  modport sink (
    input valid, input average, input step_seen, input step_total,
    input floor_total, input floor_reached, output ready
  );
endinterface

// ----- rtl/core/moving_average_step_counter.sv -----
// Moving-average step counter: each sample word enters an input register and from there,
// once the result register is free, updates the window ring, its running sum, the average
// and the step and floor counters in a single pass into the result register, so a new
// sample is taken every cycle while results are not stalled. The rate is set by the
// running-sum update and the reciprocal multiply that forms sum / WINDOW_LEN, both of
// which are combinational. A sample can wait in the input register while a result is
// stalled. The window, sum and counters are cleared directly by reset, with no clearing
// pass; configuration writes leave them untouched.
module moving_average_step_counter #(
  parameter int WINDOW_LEN  = masc_pkg::WINDOW_LEN_DEFAULT,
  parameter int SAMPLE_BITS = masc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [masc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [masc_pkg::CFG_DATA_W-1:0]  cfg_data,
  masc_sample_if.sink                      samples,
  masc_result_if.source                    results
);

  localparam int STORE_BITS = (SAMPLE_BITS < masc_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : masc_pkg::SAMPLE_W;
  localparam int SUM_W      = STORE_BITS + $clog2(WINDOW_LEN);
  localparam int SHIFT      = SUM_W + $clog2(WINDOW_LEN);
  localparam int POS_BITS   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int PROD_W     = SUM_W + SHIFT + 1;

  localparam logic [SHIFT:0] RECIP =
    (SHIFT+1)'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(WINDOW_LEN - 1);

  logic [masc_pkg::THRESHOLD_W-1:0] trigger_level;
  logic [masc_pkg::SPF_W-1:0]       steps_per_floor;

  logic                  in_valid;
  logic [STORE_BITS-1:0] in_sample;
  logic                  advance;

  logic [STORE_BITS-1:0]              sample_window [WINDOW_LEN];
  logic [POS_BITS-1:0]                pos;
  logic [SUM_W-1:0]                   window_sum;
  logic [masc_pkg::AVERAGE_W-1:0]     previous_average;
  logic [masc_pkg::STEP_TOTAL_W-1:0]  step_count;
  logic [masc_pkg::SPF_W-1:0]         steps_in_floor;
  logic [masc_pkg::FLOOR_TOTAL_W-1:0] floor_count;

  logic [SUM_W-1:0]                   window_sum_next;
  logic [PROD_W-1:0]                  product;
  logic [masc_pkg::AVERAGE_W-1:0]     average_next;
  logic                               step;
  logic                               counted;
  logic [masc_pkg::SPF_W-1:0]         need;
  logic [masc_pkg::SPF_W:0]           progress;
  logic                               floor_hit;
  logic [masc_pkg::STEP_TOTAL_W-1:0]  step_count_next;
  logic [masc_pkg::SPF_W-1:0]         steps_in_floor_next;
  logic [masc_pkg::FLOOR_TOTAL_W-1:0] floor_count_next;

  assign advance       = in_valid && (!results.valid || results.ready);
  assign samples.ready = !in_valid || advance;

  always_comb begin
    window_sum_next = window_sum - SUM_W'(sample_window[pos]) + SUM_W'(in_sample);
    product         = PROD_W'(window_sum_next) * PROD_W'(RECIP);
    average_next    = masc_pkg::AVERAGE_W'(product[SHIFT +: STORE_BITS]);
    step            = (average_next > trigger_level) && (average_next > previous_average);
    counted         = step && (step_count != masc_pkg::STEP_MAX);
    need            = (steps_per_floor == '0) ? masc_pkg::SPF_W'(1) : steps_per_floor;
    progress        = {1'b0, steps_in_floor} + (masc_pkg::SPF_W+1)'(1);
    floor_hit       = counted && (progress >= {1'b0, need});

    step_count_next     = step_count;
    steps_in_floor_next = steps_in_floor;
    floor_count_next    = floor_count;
    if (counted) begin
      step_count_next = step_count + masc_pkg::STEP_TOTAL_W'(1);
      if (floor_hit) begin
        steps_in_floor_next = '0;
        if (floor_count != masc_pkg::FLOOR_MAX) begin
          floor_count_next = floor_count + masc_pkg::FLOOR_TOTAL_W'(1);
        end
      end else begin
        steps_in_floor_next = progress[masc_pkg::SPF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level   <= masc_pkg::THRESHOLD_RESET;
      steps_per_floor <= masc_pkg::SPF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        masc_pkg::REG_TRIGGER_LEVEL: begin
          trigger_level <= cfg_data[masc_pkg::THRESHOLD_W-1:0];
        end
        masc_pkg::REG_STEPS_PER_FLOOR: begin
          steps_per_floor <= cfg_data[masc_pkg::SPF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      in_sample <= samples.sample[STORE_BITS-1:0];
    end
  end

  // window and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        sample_window[i] <= '0;
      end
      pos              <= '0;
      window_sum       <= '0;
      previous_average <= '0;
      step_count       <= '0;
      steps_in_floor   <= '0;
      floor_count      <= '0;
    end else if (advance) begin
      sample_window[pos] <= in_sample;
      pos                <= (pos == POS_LAST) ? '0 : pos + POS_BITS'(1);
      window_sum         <= window_sum_next;
      previous_average   <= average_next;
      step_count         <= step_count_next;
      steps_in_floor     <= steps_in_floor_next;
      floor_count        <= floor_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (advance) begin
      results.average       <= average_next;
      results.step_seen     <= step;
      results.step_total    <= step_count_next;
      results.floor_total   <= floor_count_next;
      results.floor_reached <= floor_hit;
    end
  end

  a_floor_needs_step: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.floor_reached || results.step_seen))
    else $error("floor flagged without a step");

  a_step_count_rate: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (step_count == $past(step_count)
                     || step_count == $past(step_count) + masc_pkg::STEP_TOTAL_W'(1)))
    else $error("step count moved by more than one");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("window position out of range");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(advance)) |-> ($stable(window_sum) && $stable(floor_count)))
    else $error("window state changed without a word");

endmodule
